// ===== sv/dhcm_pkg.sv =====
`timescale 1ns / 1ps
// dhcm_pkg: widths, constants, register codes and the hue ramp lookup
// shared by the depth-to-hue colour map unit and its channel interfaces.
package dhcm_pkg;

  localparam int unsigned DepthW = 16;
  localparam int unsigned ColW   = 8;
  localparam int unsigned HueW   = 11;                  // hue index 0..1529
  localparam int unsigned RemW   = DepthW + HueW;       // offset * 1529 fits
  localparam int unsigned CfgIdxW = 1;

  localparam logic [HueW-1:0] HueSpan = 11'd1529;
  localparam logic [HueW-1:0] Hue255  = 11'd255;
  localparam logic [HueW-1:0] Hue510  = 11'd510;
  localparam logic [HueW-1:0] Hue765  = 11'd765;
  localparam logic [HueW-1:0] Hue1020 = 11'd1020;
  localparam logic [HueW-1:0] Hue1275 = 11'd1275;

  localparam logic [DepthW-1:0] MinDepthRst = 16'd500;
  localparam logic [DepthW-1:0] MaxDepthRst = 16'd30000;

  localparam logic [ColW-1:0] ColFull = 8'd255;
  localparam logic [ColW-1:0] ColZero = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    RegMinDepth = 1'b0,
    RegMaxDepth = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
  } rgb_t;

  // piecewise-linear hue ramp
  function automatic rgb_t hue_to_rgb(input logic [HueW-1:0] d);
    rgb_t c;
    logic [HueW-1:0] r_fall;
    logic [HueW-1:0] r_rise;
    logic [HueW-1:0] g_fall;
    logic [HueW-1:0] b_rise;
    logic [HueW-1:0] b_fall;
    r_fall = Hue510 - d;
    r_rise = d - Hue1020;
    g_fall = Hue765 - d;
    b_rise = d - Hue765;
    b_fall = HueSpan - d;

    if (d <= Hue255)       c.red = ColFull;
    else if (d <= Hue510)  c.red = r_fall[ColW-1:0];
    else if (d <= Hue1020) c.red = ColZero;
    else if (d <= Hue1275) c.red = r_rise[ColW-1:0];
    else                   c.red = ColFull;

    if (d <= Hue255)      c.green = d[ColW-1:0];
    else if (d <= Hue510) c.green = ColFull;
    else if (d <= Hue765) c.green = g_fall[ColW-1:0];
    else                  c.green = ColZero;

    if (d <= Hue765)       c.blue = ColZero;
    else if (d <= Hue1020) c.blue = b_rise[ColW-1:0];
    else if (d <= Hue1275) c.blue = ColFull;
    else                   c.blue = b_fall[ColW-1:0];
    return c;
  endfunction

endpackage

// ===== sv/dhcm_if.sv =====
`timescale 1ns / 1ps
// dhcm channel interfaces: depth pixel stream, rgb pixel stream and the
// configuration write channel. depends on dhcm_pkg.

interface dhcm_depth_if;
  logic                         valid;
  logic                         ready;
  logic [dhcm_pkg::DepthW-1:0]  depth;
  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

interface dhcm_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [dhcm_pkg::ColW-1:0]  red;
  logic [dhcm_pkg::ColW-1:0]  green;
  logic [dhcm_pkg::ColW-1:0]  blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface dhcm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dhcm_pkg::CfgIdxW-1:0]  index;
  logic [dhcm_pkg::DepthW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/depth_to_hue_color_map_unit.sv =====
`timescale 1ns / 1ps
// depth_to_hue_color_map_unit: clamps each depth pixel, scales it to a hue
// index through a pipelined divider and maps it to rgb. depends on dhcm_pkg, dhcm_if.
//
//   channel  | dir | handshake    | payload
//   pix_i    | in  | valid/ready  | depth[15:0]
//   rgb_o    | out | valid/ready  | red[7:0], green[7:0], blue[7:0]
//   cfg_i    | in  | valid/ready  | index[0] (0 lower limit, 1 upper limit), data[15:0]
//
// one pixel per clock unless rgb_o stalls; 14 register stages from accept to rgb_o.valid:
// clamp, multiply by 1529, eleven restoring divide stages (one quotient bit each), colour map.
// reset sets the lower limit to 500 and the upper limit to 30000 and empties the pipeline.
// each stage holds while it is full and the one after it cannot move, so bubbles
// close up; pix_i.ready drops only when every stage is full and rgb_o is stalled.
// cfg_i is always ready.
module depth_to_hue_color_map_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhcm_depth_if.sink pix_i,
  dhcm_rgb_if.source rgb_o,
  dhcm_cfg_if.sink   cfg_i
);
  import dhcm_pkg::*;

  localparam int unsigned DivN  = HueW;          // one stage per quotient bit
  localparam int unsigned StgN  = DivN + 3;
  localparam int unsigned OutS  = StgN - 1;

  logic [DepthW-1:0] min_q, max_q;
  logic [DepthW-1:0] span_q, span_d;

  logic [StgN-1:0] valid_q;
  logic [StgN:0]   en;

  logic [DepthW-1:0] clamp_d, off_d, off_q;
  logic [RemW-1:0]   prod_q;
  logic [RemW-1:0]   rem_q [DivN];
  logic [HueW-1:0]   quo_q [DivN];
  rgb_t              rgb_q;
  logic              range_ok;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinDepthRst;
      max_q <= MaxDepthRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        RegMinDepth: min_q <= cfg_i.data;
        RegMaxDepth: max_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // divisor; an empty range gets an all-ones divisor so the zero offset divides to 0
  assign range_ok = max_q > min_q;
  assign span_d   = range_ok ? (max_q - min_q) : '1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= MaxDepthRst - MinDepthRst;
    end else begin
      span_q <= span_d;
    end
  end

  // stage enables, bubbles collapse
  always_comb begin
    en[StgN] = rgb_o.ready;
    for (int k = StgN - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= pix_i.valid;
      for (int k = 1; k < StgN; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // clamp and offset
  always_comb begin
    clamp_d = (pix_i.depth > max_q) ? max_q : pix_i.depth;
    clamp_d = (clamp_d < min_q) ? min_q : clamp_d;
    off_d   = range_ok ? (clamp_d - min_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) off_q <= off_d;
  end

  // scale by hue span
  always_ff @(posedge clk_i) begin
    if (en[1]) prod_q <= RemW'(off_q) * RemW'(HueSpan);
  end

  // restoring divide, most significant quotient bit first
  for (genvar j = 0; j < DivN; j++) begin : g_div
    localparam int unsigned Sh = DivN - 1 - j;
    logic [RemW-1:0] rem_in;
    logic [HueW-1:0] quo_in;
    logic [RemW-1:0] trial;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_in = prod_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = RemW'(span_q) << Sh;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en[j+2]) begin
        rem_q[j] <= take ? (rem_in - trial) : rem_in;
        quo_q[j] <= {quo_in[HueW-2:0], take};
      end
    end
  end

  // colour map
  always_ff @(posedge clk_i) begin
    if (en[OutS]) rgb_q <= hue_to_rgb(quo_q[DivN-1]);
  end

  assign rgb_o.valid = valid_q[OutS];
  assign rgb_o.red   = rgb_q.red;
  assign rgb_o.green = rgb_q.green;
  assign rgb_o.blue  = rgb_q.blue;

endmodule
